FILE: rtl/hvn_pkg.sv
package hvn_pkg;

  // default sizes of the height store
  localparam int MAX_COLS_DEF    = 256;
  localparam int MAX_ROWS_DEF    = 256;
  localparam int HEIGHT_BITS_DEF = 16;

  // port and field widths
  localparam int COMP_W    = 20;
  localparam int VEC_W     = 60;
  localparam int VTX_W     = 24;
  localparam int NRM_W     = 16;
  localparam int GRID_W    = 9;
  localparam int COORD_W   = 8;
  localparam int IN_H_W    = 16;
  localparam int CFG_IDX_W = 3;
  localparam int SIZE_W    = 13;

  // internal arithmetic widths
  localparam int DIFF_W  = VTX_W + 1;
  localparam int PROD_W  = 2 * DIFF_W;
  localparam int CROSS_W = PROD_W + 1;
  localparam int MAG_W   = CROSS_W;
  localparam int NM_W    = 31;
  localparam int SQ_W    = 2 * NM_W;
  localparam int RAD_W   = 64;
  localparam int LEN_W   = 33;
  localparam int QUO_W   = 15;
  localparam int FRAC_W  = 14;
  localparam int NUM_W   = NM_W + FRAC_W + 1;
  localparam int REM_W   = LEN_W + 1;

  // sequencing counts
  localparam int NUM_PTS    = 5;
  localparam int VTX_LAT    = 2;
  localparam int SQRT_STEPS = RAD_W / 2;
  localparam int DIV_STEPS  = QUO_W;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COL_STEP    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_STEP    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT_STEP = 3'd5;

  // grid points visited by one query
  typedef enum logic [2:0] {
    PT_CENTER, PT_LEFT, PT_RIGHT, PT_UPPER, PT_LOWER
  } pt_t;

  // kind of result word
  typedef enum logic [1:0] {
    RES_NORMAL, RES_OOR, RES_DEGEN
  } res_kind_t;

  // commands from controller to datapath
  typedef struct packed {
    logic      wr_en;
    logic      load;
    logic      rd_en;
    pt_t       rd_pt;
    logic      cdiff;
    logic      cmul;
    logic      csub;
    logic      nabs;
    logic      norm_step;
    logic      sqmul;
    logic      sqsum;
    logic      sqrt_step;
    logic      dinit;
    logic      div_step;
    logic      out_load;
    res_kind_t res_kind;
  } dp_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic oor;
    logic zero;
    logic norm_ok;
  } dp_sts_t;

endpackage

FILE: rtl/hvn_ram.sv
module hvn_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/hvn_ctrl.sv
module hvn_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              action,
  output logic              out_valid,
  input  logic              out_ready,
  output hvn_pkg::dp_cmd_t  cmd,
  input  hvn_pkg::dp_sts_t  sts
);

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_READ, S_VWAIT, S_CDIFF, S_CMUL, S_CSUB, S_NABS,
    S_NORM, S_SQMUL, S_SQSUM, S_SQRT, S_DINIT, S_DIV, S_DONE
  } state_t;

  state_t                 state, state_next;
  logic [4:0]             cnt, cnt_next;
  hvn_pkg::res_kind_t     kind, kind_next;

  assign in_ready = (state == S_IDLE);

  // next state and datapath commands
  always_comb begin
    cmd          = '0;
    cmd.res_kind = kind;
    state_next   = state;
    cnt_next     = cnt;
    kind_next    = kind;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (action) begin
            cmd.load   = 1'b1;
            state_next = S_CHECK;
          end else begin
            cmd.wr_en = 1'b1;
          end
        end
      end
      S_CHECK: begin
        cnt_next = '0;
        if (sts.oor) begin
          kind_next  = hvn_pkg::RES_OOR;
          state_next = S_DONE;
        end else begin
          kind_next  = hvn_pkg::RES_NORMAL;
          state_next = S_READ;
        end
      end
      S_READ: begin
        cmd.rd_en = 1'b1;
        cmd.rd_pt = hvn_pkg::pt_t'(cnt[2:0]);
        if (cnt == 5'(hvn_pkg::NUM_PTS - 1)) begin
          cnt_next   = '0;
          state_next = S_VWAIT;
        end else begin
          cnt_next = cnt + 5'd1;
        end
      end
      S_VWAIT: begin
        if (cnt == 5'(hvn_pkg::VTX_LAT - 1)) begin
          cnt_next   = '0;
          state_next = S_CDIFF;
        end else begin
          cnt_next = cnt + 5'd1;
        end
      end
      S_CDIFF: begin
        cmd.cdiff  = 1'b1;
        state_next = S_CMUL;
      end
      S_CMUL: begin
        cmd.cmul   = 1'b1;
        state_next = S_CSUB;
      end
      S_CSUB: begin
        cmd.csub   = 1'b1;
        state_next = S_NABS;
      end
      S_NABS: begin
        cmd.nabs   = 1'b1;
        state_next = S_NORM;
      end
      S_NORM: begin
        if (sts.zero) begin
          kind_next  = hvn_pkg::RES_DEGEN;
          state_next = S_DONE;
        end else if (sts.norm_ok) begin
          state_next = S_SQMUL;
        end else begin
          cmd.norm_step = 1'b1;
        end
      end
      S_SQMUL: begin
        cmd.sqmul  = 1'b1;
        state_next = S_SQSUM;
      end
      S_SQSUM: begin
        cmd.sqsum  = 1'b1;
        cnt_next   = '0;
        state_next = S_SQRT;
      end
      S_SQRT: begin
        cmd.sqrt_step = 1'b1;
        if (cnt == 5'(hvn_pkg::SQRT_STEPS - 1)) begin
          cnt_next   = '0;
          state_next = S_DINIT;
        end else begin
          cnt_next = cnt + 5'd1;
        end
      end
      S_DINIT: begin
        cmd.dinit  = 1'b1;
        cnt_next   = '0;
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt == 5'(hvn_pkg::DIV_STEPS - 1)) begin
          cnt_next   = '0;
          state_next = S_DONE;
        end else begin
          cnt_next = cnt + 5'd1;
        end
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // state and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      kind      <= hvn_pkg::RES_NORMAL;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      kind  <= kind_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

FILE: rtl/hvn_dp.sv
module hvn_dp #(
  parameter int MAX_COLS    = hvn_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS    = hvn_pkg::MAX_ROWS_DEF,
  parameter int HEIGHT_BITS = hvn_pkg::HEIGHT_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  hvn_pkg::dp_cmd_t                      cmd,
  output hvn_pkg::dp_sts_t                      sts,
  input  logic                                  cfg_we,
  input  logic [hvn_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [hvn_pkg::VEC_W-1:0]             cfg_data,
  input  logic [hvn_pkg::COORD_W-1:0]           col,
  input  logic [hvn_pkg::COORD_W-1:0]           row,
  input  logic [hvn_pkg::IN_H_W-1:0]            height,
  output logic signed [hvn_pkg::VTX_W-1:0]      vertex_x,
  output logic signed [hvn_pkg::VTX_W-1:0]      vertex_y,
  output logic signed [hvn_pkg::VTX_W-1:0]      vertex_z,
  output logic signed [hvn_pkg::NRM_W-1:0]      normal_x,
  output logic signed [hvn_pkg::NRM_W-1:0]      normal_y,
  output logic signed [hvn_pkg::NRM_W-1:0]      normal_z,
  output logic                                  degenerate,
  output logic                                  out_of_range
);

  localparam int AW    = $clog2(MAX_COLS * MAX_ROWS);
  localparam int CW    = hvn_pkg::COORD_W;
  localparam int SW    = hvn_pkg::SIZE_W;
  localparam int SUM_W = HEIGHT_BITS + 24;
  localparam int PC_W  = CW + hvn_pkg::COMP_W + 1;
  localparam int PH_W  = HEIGHT_BITS + hvn_pkg::COMP_W + 1;
  localparam int VW    = hvn_pkg::VTX_W;
  localparam int DW    = hvn_pkg::DIFF_W;
  localparam int MW    = hvn_pkg::MAG_W;
  localparam int NMW   = hvn_pkg::NM_W;
  localparam int QW    = hvn_pkg::QUO_W;
  localparam int RW    = hvn_pkg::REM_W;
  localparam int LW    = hvn_pkg::LEN_W;
  localparam int RADW  = hvn_pkg::RAD_W;

  function automatic logic signed [hvn_pkg::COMP_W-1:0] vec_comp(
    input logic [hvn_pkg::VEC_W-1:0] v, input int k);
    return v[hvn_pkg::COMP_W*k +: hvn_pkg::COMP_W];
  endfunction

  function automatic logic signed [VW-1:0] sat_vtx(input logic signed [SUM_W-1:0] s);
    logic signed [SUM_W-1:0] hi, lo;
    hi = SUM_W'(signed'({1'b0, {(VW-1){1'b1}}}));
    lo = -hi - SUM_W'(1);
    if (s > hi) return hi[VW-1:0];
    if (s < lo) return lo[VW-1:0];
    return s[VW-1:0];
  endfunction

  // configuration registers
  logic [hvn_pkg::GRID_W-1:0] grid_cols, grid_rows;
  logic [hvn_pkg::VEC_W-1:0]  origin_vec, col_step_vec, row_step_vec, height_step_vec;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_cols       <= hvn_pkg::GRID_W'(256);
      grid_rows       <= hvn_pkg::GRID_W'(256);
      origin_vec      <= '0;
      col_step_vec    <= '0;
      row_step_vec    <= '0;
      height_step_vec <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        hvn_pkg::REG_GRID_COLS:   grid_cols       <= cfg_data[hvn_pkg::GRID_W-1:0];
        hvn_pkg::REG_GRID_ROWS:   grid_rows       <= cfg_data[hvn_pkg::GRID_W-1:0];
        hvn_pkg::REG_ORIGIN:      origin_vec      <= cfg_data;
        hvn_pkg::REG_COL_STEP:    col_step_vec    <= cfg_data;
        hvn_pkg::REG_ROW_STEP:    row_step_vec    <= cfg_data;
        hvn_pkg::REG_HEIGHT_STEP: height_step_vec <= cfg_data;
        default: ;
      endcase
    end
  end

  // effective grid size
  logic [SW-1:0] cols_eff, rows_eff;

  always_comb begin
    if (grid_cols == '0) cols_eff = SW'(1);
    else if (SW'(grid_cols) > SW'(MAX_COLS)) cols_eff = SW'(MAX_COLS);
    else cols_eff = SW'(grid_cols);
    if (grid_rows == '0) rows_eff = SW'(1);
    else if (SW'(grid_rows) > SW'(MAX_ROWS)) rows_eff = SW'(MAX_ROWS);
    else rows_eff = SW'(grid_rows);
  end

  // query point
  logic [CW-1:0] qc, qr;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      qc <= col;
      qr <= row;
    end
  end

  assign sts.oor = (SW'(qc) >= cols_eff) || (SW'(qr) >= rows_eff);

  // neighbor coordinates, clamped at the border
  logic [CW-1:0] c_left, c_right, r_up, r_down, pc, pr;

  assign c_left  = (qc != '0) ? qc - CW'(1) : qc;
  assign c_right = (SW'(qc) + SW'(1) < cols_eff) ? qc + CW'(1) : qc;
  assign r_up    = (qr != '0) ? qr - CW'(1) : qr;
  assign r_down  = (SW'(qr) + SW'(1) < rows_eff) ? qr + CW'(1) : qr;

  always_comb begin
    pc = qc;
    pr = qr;
    case (cmd.rd_pt)
      hvn_pkg::PT_LEFT:  pc = c_left;
      hvn_pkg::PT_RIGHT: pc = c_right;
      hvn_pkg::PT_UPPER: pr = r_up;
      hvn_pkg::PT_LOWER: pr = r_down;
      default: ;
    endcase
  end

  // height store
  logic [AW-1:0]          wr_addr, rd_addr;
  logic                   wr_ok;
  logic [HEIGHT_BITS-1:0] ram_q;

  assign wr_addr = AW'(row) * AW'(MAX_COLS) + AW'(col);
  assign rd_addr = AW'(pr) * AW'(MAX_COLS) + AW'(pc);
  assign wr_ok   = cmd.wr_en && (SW'(col) < SW'(MAX_COLS)) && (SW'(row) < SW'(MAX_ROWS));

  hvn_ram #(
    .WIDTH (HEIGHT_BITS),
    .DEPTH (MAX_COLS * MAX_ROWS)
  ) u_ram (
    .clk   (clk),
    .we    (wr_ok),
    .waddr (wr_addr),
    .wdata (height[HEIGHT_BITS-1:0]),
    .raddr (rd_addr),
    .rdata (ram_q)
  );

  // vertex pipeline: read, products, sum and saturate
  logic                     s1_valid, s2_valid;
  hvn_pkg::pt_t             s1_pt, s2_pt;
  logic [CW-1:0]            s1_c, s1_r;
  logic signed [PC_W-1:0]   prod_c [3];
  logic signed [PC_W-1:0]   prod_r [3];
  logic signed [PH_W-1:0]   prod_h [3];
  logic signed [VW-1:0]     vtx [hvn_pkg::NUM_PTS][3];

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      s1_valid <= cmd.rd_en;
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_pt <= cmd.rd_pt;
    s1_c  <= pc;
    s1_r  <= pr;
    s2_pt <= s1_pt;
    for (int k = 0; k < 3; k++) begin
      prod_c[k] <= $signed({1'b0, s1_c}) * vec_comp(col_step_vec, k);
      prod_r[k] <= $signed({1'b0, s1_r}) * vec_comp(row_step_vec, k);
      prod_h[k] <= $signed({1'b0, ram_q}) * vec_comp(height_step_vec, k);
    end
    if (s2_valid) begin
      for (int k = 0; k < 3; k++) begin
        vtx[s2_pt][k] <= sat_vtx(SUM_W'(vec_comp(origin_vec, k)) + SUM_W'(prod_c[k])
                                 + SUM_W'(prod_r[k]) + SUM_W'(prod_h[k]));
      end
    end
  end

  // cross product of the two central differences
  logic signed [DW-1:0]               a [3];
  logic signed [DW-1:0]               b [3];
  logic signed [hvn_pkg::PROD_W-1:0]  cp [6];
  logic signed [hvn_pkg::CROSS_W-1:0] n [3];
  logic [MW-1:0]                      m [3];
  logic                               neg [3];

  always_ff @(posedge clk) begin
    if (cmd.cdiff) begin
      for (int k = 0; k < 3; k++) begin
        a[k] <= DW'(vtx[hvn_pkg::PT_UPPER][k]) - DW'(vtx[hvn_pkg::PT_LOWER][k]);
        b[k] <= DW'(vtx[hvn_pkg::PT_RIGHT][k]) - DW'(vtx[hvn_pkg::PT_LEFT][k]);
      end
    end
    if (cmd.cmul) begin
      cp[0] <= a[1] * b[2];
      cp[1] <= a[2] * b[1];
      cp[2] <= a[2] * b[0];
      cp[3] <= a[0] * b[2];
      cp[4] <= a[0] * b[1];
      cp[5] <= a[1] * b[0];
    end
    if (cmd.csub) begin
      for (int k = 0; k < 3; k++) begin
        n[k] <= hvn_pkg::CROSS_W'(cp[2*k]) - hvn_pkg::CROSS_W'(cp[2*k+1]);
      end
    end
  end

  // magnitude maximum and normalizing shift
  logic [MW-1:0] mx;

  always_comb begin
    mx = m[0];
    if (m[1] > mx) mx = m[1];
    if (m[2] > mx) mx = m[2];
  end

  assign sts.zero    = (mx == '0);
  assign sts.norm_ok = (mx[MW-1:31] == '0) && mx[30];

  always_ff @(posedge clk) begin
    if (cmd.nabs) begin
      for (int k = 0; k < 3; k++) begin
        neg[k] <= n[k][hvn_pkg::CROSS_W-1];
        m[k]   <= n[k][hvn_pkg::CROSS_W-1] ? MW'(-n[k]) : MW'(n[k]);
      end
    end else if (cmd.norm_step) begin
      for (int k = 0; k < 3; k++) begin
        if (|mx[MW-1:35]) m[k] <= m[k] >> 4;
        else if (|mx[MW-1:31]) m[k] <= m[k] >> 1;
        else if (mx[MW-1:26] == '0) m[k] <= m[k] << 4;
        else m[k] <= m[k] << 1;
      end
    end
  end

  // sum of squares and bitwise square root
  logic [hvn_pkg::SQ_W-1:0] sq [3];
  logic [RADW-1:0]          rad_x, rad_res, rad_bit, rad_t;

  assign rad_t = rad_res + rad_bit;

  always_ff @(posedge clk) begin
    if (cmd.sqmul) begin
      for (int k = 0; k < 3; k++) begin
        sq[k] <= m[k][NMW-1:0] * m[k][NMW-1:0];
      end
    end
    if (cmd.sqsum) begin
      rad_x   <= RADW'(sq[0]) + RADW'(sq[1]) + RADW'(sq[2]);
      rad_res <= '0;
      rad_bit <= RADW'(1) << (RADW - 2);
    end else if (cmd.sqrt_step) begin
      if (rad_x >= rad_t) begin
        rad_x   <= rad_x - rad_t;
        rad_res <= (rad_res >> 1) + rad_bit;
      end else begin
        rad_res <= rad_res >> 1;
      end
      rad_bit <= rad_bit >> 2;
    end
  end

  // three restoring dividers in lockstep
  logic [LW-1:0]            len;
  logic [hvn_pkg::NUM_W-1:0] num [3];
  logic [RW-1:0]            rem [3];
  logic [RW-1:0]            rr [3];
  logic [QW-1:0]            nlo [3];
  logic [QW-1:0]            quo [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      num[k] = hvn_pkg::NUM_W'({m[k][NMW-1:0], {hvn_pkg::FRAC_W{1'b0}}})
               + hvn_pkg::NUM_W'(rad_res[LW-1:1]);
      rr[k]  = {rem[k][RW-2:0], nlo[k][QW-1]};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.dinit) begin
      len <= rad_res[LW-1:0];
      for (int k = 0; k < 3; k++) begin
        rem[k] <= RW'(num[k][hvn_pkg::NUM_W-1:QW]);
        nlo[k] <= num[k][QW-1:0];
        quo[k] <= '0;
      end
    end else if (cmd.div_step) begin
      for (int k = 0; k < 3; k++) begin
        nlo[k] <= nlo[k] << 1;
        if (rr[k] >= RW'(len)) begin
          rem[k] <= rr[k] - RW'(len);
          quo[k] <= {quo[k][QW-2:0], 1'b1};
        end else begin
          rem[k] <= rr[k];
          quo[k] <= {quo[k][QW-2:0], 1'b0};
        end
      end
    end
  end

  // result word register
  logic signed [hvn_pkg::NRM_W-1:0] nrm [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      nrm[k] = neg[k] ? -hvn_pkg::NRM_W'(quo[k]) : hvn_pkg::NRM_W'(quo[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      vertex_x     <= vtx[hvn_pkg::PT_CENTER][0];
      vertex_y     <= vtx[hvn_pkg::PT_CENTER][1];
      vertex_z     <= vtx[hvn_pkg::PT_CENTER][2];
      normal_x     <= nrm[0];
      normal_y     <= nrm[1];
      normal_z     <= nrm[2];
      degenerate   <= 1'b0;
      out_of_range <= 1'b0;
      case (cmd.res_kind)
        hvn_pkg::RES_OOR: begin
          vertex_x     <= '0;
          vertex_y     <= '0;
          vertex_z     <= '0;
          normal_x     <= '0;
          normal_y     <= '0;
          normal_z     <= '0;
          out_of_range <= 1'b1;
        end
        hvn_pkg::RES_DEGEN: begin
          normal_x   <= '0;
          normal_y   <= '0;
          normal_z   <= '0;
          degenerate <= 1'b1;
        end
        default: ;
      endcase
    end
  end

endmodule

FILE: rtl/heightfield_vertex_normal_unit.sv
// Height-field vertex and normal unit.
// Input channel (in_valid/in_ready): action 0 stores height at (col, row),
// one word per cycle while idle, no result; action 1 queries the point and
// returns one result word on the output channel (out_valid/out_ready).
// Config channel (cfg_valid/cfg_ready, always ready) writes grid size and the
// four Q4.16 vectors; write it only while no query is in flight.
// A query runs these steps in order from accept to result: five height
// reads from the single store read port, vertex pipeline, cross product,
// a normalizing shift, a square root and a divider for the three
// components. A query outside the grid returns from the range check, a
// zero-length normal from the normalizing step. One query is worked at a
// time; the next word is taken as soon as the controller is idle again.
// The result sits in an output register, so a stalled receiver does not
// block new input words; only the finish of the next query waits for it.
// Reset is synchronous, clears control state and restores the config
// registers (256 by 256 grid, zero vectors); the height store keeps its
// content and must be written before it is read.
module heightfield_vertex_normal_unit #(
  parameter int MAX_COLS    = hvn_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS    = hvn_pkg::MAX_ROWS_DEF,
  parameter int HEIGHT_BITS = hvn_pkg::HEIGHT_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               action,
  input  logic [hvn_pkg::COORD_W-1:0]        col,
  input  logic [hvn_pkg::COORD_W-1:0]        row,
  input  logic [hvn_pkg::IN_H_W-1:0]         height,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [hvn_pkg::VTX_W-1:0]   vertex_x,
  output logic signed [hvn_pkg::VTX_W-1:0]   vertex_y,
  output logic signed [hvn_pkg::VTX_W-1:0]   vertex_z,
  output logic signed [hvn_pkg::NRM_W-1:0]   normal_x,
  output logic signed [hvn_pkg::NRM_W-1:0]   normal_y,
  output logic signed [hvn_pkg::NRM_W-1:0]   normal_z,
  output logic                               degenerate,
  output logic                               out_of_range,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [hvn_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [hvn_pkg::VEC_W-1:0]          cfg_data
);

  hvn_pkg::dp_cmd_t cmd;
  hvn_pkg::dp_sts_t sts;

  assign cfg_ready = 1'b1;

  // sequencer
  hvn_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .action    (action),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // store, arithmetic and result register
  hvn_dp #(
    .MAX_COLS    (MAX_COLS),
    .MAX_ROWS    (MAX_ROWS),
    .HEIGHT_BITS (HEIGHT_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .cfg_we       (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .col          (col),
    .row          (row),
    .height       (height),
    .vertex_x     (vertex_x),
    .vertex_y     (vertex_y),
    .vertex_z     (vertex_z),
    .normal_x     (normal_x),
    .normal_y     (normal_y),
    .normal_z     (normal_z),
    .degenerate   (degenerate),
    .out_of_range (out_of_range)
  );

  // a query leaves the idle state at once
  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && action |=> !in_ready)
    else $error("query accepted but input still ready");

  // flags are exclusive
  a_flags: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(degenerate && out_of_range))
    else $error("degenerate and out_of_range both set");

  // out of range results carry zero vertex
  a_oor_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_of_range |-> vertex_x == '0 && vertex_y == '0 && vertex_z == '0)
    else $error("out of range result with nonzero vertex");

  // unit normal components stay within one
  a_nrm_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> normal_x >= -16'sd16384 && normal_x <= 16'sd16384
               && normal_y >= -16'sd16384 && normal_y <= 16'sd16384
               && normal_z >= -16'sd16384 && normal_z <= 16'sd16384)
    else $error("normal component out of range");

endmodule

FILE: test/tb_heightfield_vertex_normal_unit.sv
module tb_heightfield_vertex_normal_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import hvn_pkg::*;

  localparam int GRID_DIM = 256;

  typedef longint vec3_t [3];

  // one result word as the block should return it
  typedef struct {
    logic signed [VTX_W-1:0] vx, vy, vz;
    logic signed [NRM_W-1:0] nx, ny, nz;
    logic                    degen;
    logic                    oor;
  } vn_word_t;

  // predicts vertex and normal words and matches them against the block
  class vn_scoreboard;
    logic [IN_H_W-1:0] heights [GRID_DIM*GRID_DIM];
    bit                written [GRID_DIM*GRID_DIM];
    logic [GRID_W-1:0] cols_reg = GRID_W'(256);
    logic [GRID_W-1:0] rows_reg = GRID_W'(256);
    logic [VEC_W-1:0]  origin = '0, cstep = '0, rstep = '0, hstep = '0;
    vn_word_t          pending_words [$];
    int                errors = 0;

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [VEC_W-1:0] data);
      case (idx)
        REG_GRID_COLS:   cols_reg = data[GRID_W-1:0];
        REG_GRID_ROWS:   rows_reg = data[GRID_W-1:0];
        REG_ORIGIN:      origin = data;
        REG_COL_STEP:    cstep = data;
        REG_ROW_STEP:    rstep = data;
        REG_HEIGHT_STEP: hstep = data;
        default: ;
      endcase
    endfunction

    function int cols_eff();
      if (cols_reg == 0) return 1;
      if (cols_reg > GRID_DIM) return GRID_DIM;
      return int'(cols_reg);
    endfunction

    function int rows_eff();
      if (rows_reg == 0) return 1;
      if (rows_reg > GRID_DIM) return GRID_DIM;
      return int'(rows_reg);
    endfunction

    function bit is_written(int c, int r);
      return written[r*GRID_DIM + c];
    endfunction

    function longint comp(logic [VEC_W-1:0] v, int k);
      logic signed [COMP_W-1:0] t;
      t = v[k*COMP_W +: COMP_W];
      return longint'(t);
    endfunction

    // saturated vertex of one grid point
    function vec3_t vertex(int c, int r);
      vec3_t  v;
      longint h, s;
      h = longint'(heights[r*GRID_DIM + c]);
      for (int k = 0; k < 3; k++) begin
        s = comp(origin, k) + c * comp(cstep, k) + r * comp(rstep, k) + h * comp(hstep, k);
        if (s > 64'sd8388607) s = 64'sd8388607;
        if (s < -64'sd8388608) s = -64'sd8388608;
        v[k] = s;
      end
      return v;
    endfunction

    function longint unsigned isqrt(longint unsigned x);
      longint unsigned res, b;
      res = 0;
      b = 64'h4000_0000_0000_0000;
      while (b > x) b >>= 2;
      while (b != 0) begin
        if (x >= res + b) begin
          x -= res + b;
          res = (res >> 1) + b;
        end else begin
          res >>= 1;
        end
        b >>= 2;
      end
      return res;
    endfunction

    // accepted input word: store a height or queue the predicted result
    function void note_input(bit act, int c, int r, logic [IN_H_W-1:0] h);
      vn_word_t        w;
      vec3_t           vc, vl, vr, vo, vu;
      longint          a [3], b [3], n [3];
      longint unsigned m [3], mx, len, q;
      int              sh, cols, rows;
      if (!act) begin
        heights[r*GRID_DIM + c] = h;
        written[r*GRID_DIM + c] = 1'b1;
        return;
      end
      w = '{default: '0};
      cols = cols_eff();
      rows = rows_eff();
      if (c >= cols || r >= rows) begin
        w.oor = 1'b1;
        pending_words.push_back(w);
        return;
      end
      vc = vertex(c, r);
      vl = vertex(c > 0 ? c - 1 : c, r);
      vr = vertex(c + 1 < cols ? c + 1 : c, r);
      vo = vertex(c, r > 0 ? r - 1 : r);
      vu = vertex(c, r + 1 < rows ? r + 1 : r);
      w.vx = vc[0][VTX_W-1:0];
      w.vy = vc[1][VTX_W-1:0];
      w.vz = vc[2][VTX_W-1:0];
      for (int k = 0; k < 3; k++) begin
        a[k] = vo[k] - vu[k];
        b[k] = vr[k] - vl[k];
      end
      n[0] = a[1] * b[2] - a[2] * b[1];
      n[1] = a[2] * b[0] - a[0] * b[2];
      n[2] = a[0] * b[1] - a[1] * b[0];
      mx = 0;
      for (int k = 0; k < 3; k++) begin
        m[k] = n[k] < 0 ? longint'(-n[k]) : longint'(n[k]);
        if (m[k] > mx) mx = m[k];
      end
      if (mx == 0) begin
        w.degen = 1'b1;
        pending_words.push_back(w);
        return;
      end
      // common shift so the largest magnitude lands in [2^30, 2^31)
      sh = 0;
      while (mx >= 64'd2147483648) begin mx >>= 1; sh++; end
      while (mx < 64'd1073741824) begin mx <<= 1; sh--; end
      for (int k = 0; k < 3; k++) begin
        if (sh > 0) m[k] >>= sh;
        else if (sh < 0) m[k] <<= -sh;
      end
      len = isqrt(m[0] * m[0] + m[1] * m[1] + m[2] * m[2]);
      for (int k = 0; k < 3; k++) begin
        q = (m[k] * 16384 + len / 2) / len;
        if (q > 16384) q = 16384;
        if (n[k] < 0) q = -q;
        case (k)
          0: w.nx = q[NRM_W-1:0];
          1: w.ny = q[NRM_W-1:0];
          default: w.nz = q[NRM_W-1:0];
        endcase
      end
      pending_words.push_back(w);
    endfunction

    function void cmp(string name, longint e, longint act);
      if (e != act) begin
        $error("%s expected %0d got %0d", name, e, act);
        errors++;
      end
    endfunction

    function void check_result(vn_word_t act);
      vn_word_t e;
      if (pending_words.size() == 0) begin
        $error("result word with nothing expected");
        errors++;
        return;
      end
      e = pending_words.pop_front();
      cmp("vertex_x", e.vx, act.vx);
      cmp("vertex_y", e.vy, act.vy);
      cmp("vertex_z", e.vz, act.vz);
      cmp("normal_x", e.nx, act.nx);
      cmp("normal_y", e.ny, act.ny);
      cmp("normal_z", e.nz, act.nz);
      cmp("degenerate", e.degen, act.degen);
      cmp("out_of_range", e.oor, act.oor);
    endfunction
  endclass

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic                    action = 1'b0;
  logic [COORD_W-1:0]      col = '0;
  logic [COORD_W-1:0]      row = '0;
  logic [IN_H_W-1:0]       height = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic signed [VTX_W-1:0] vertex_x, vertex_y, vertex_z;
  logic signed [NRM_W-1:0] normal_x, normal_y, normal_z;
  logic                    degenerate, out_of_range;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [CFG_IDX_W-1:0]    cfg_index = '0;
  logic [VEC_W-1:0]        cfg_data = '0;

  vn_scoreboard sb;
  int           snd_idle = 28;
  int           rcv_idle = 69;
  int           items_sent = 0;

  heightfield_vertex_normal_unit dut (
    .clk, .rst, .in_valid, .in_ready, .action, .col, .row, .height,
    .out_valid, .out_ready, .vertex_x, .vertex_y, .vertex_z,
    .normal_x, .normal_y, .normal_z, .degenerate, .out_of_range,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  always #4 clk = ~clk;

  // receiver stalls
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= rcv_idle);
  end

  // result monitor
  always @(posedge clk) begin
    vn_word_t w;
    if (!rst && out_valid && out_ready) begin
      w.vx = vertex_x; w.vy = vertex_y; w.vz = vertex_z;
      w.nx = normal_x; w.ny = normal_y; w.nz = normal_z;
      w.degen = degenerate; w.oor = out_of_range;
      sb.check_result(w);
    end
  end

  // one input word; valid stays up for back-to-back words
  task automatic send(bit act, int c, int r, logic [IN_H_W-1:0] h);
    if ($urandom_range(99) < snd_idle) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < snd_idle);
    end
    in_valid <= 1'b1;
    action <= act;
    col <= COORD_W'(c);
    row <= COORD_W'(r);
    height <= h;
    do @(posedge clk); while (!in_ready);
    sb.note_input(act, c, r, h);
    items_sent++;
  endtask

  task automatic write_height(int c, int r, logic [IN_H_W-1:0] h);
    send(1'b0, c, r, h);
  endtask

  // fill any unwritten point the query will read, then query
  task automatic query_point(int c, int r);
    int cols, rows;
    int pc [5], pr [5];
    cols = sb.cols_eff();
    rows = sb.rows_eff();
    if (c < cols && r < rows) begin
      pc = '{c, c > 0 ? c - 1 : c, c + 1 < cols ? c + 1 : c, c, c};
      pr = '{r, r, r, r > 0 ? r - 1 : r, r + 1 < rows ? r + 1 : r};
      for (int i = 0; i < 5; i++)
        if (!sb.is_written(pc[i], pr[i]))
          write_height(pc[i], pr[i], IN_H_W'($urandom));
    end
    send(1'b1, c, r, '0);
  endtask

  // drop valid and let the block finish everything in flight
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending_words.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [VEC_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, data);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [VEC_W-1:0] pack3(int x, int y, int z);
    return {COMP_W'(z), COMP_W'(y), COMP_W'(x)};
  endfunction

  // random vector: small, full range, extreme or realistic components
  function automatic logic [VEC_W-1:0] rand_vec();
    logic [VEC_W-1:0] v;
    int               t;
    for (int k = 0; k < 3; k++) begin
      case ($urandom_range(3))
        0: t = $urandom_range(8191) - 4096;
        1: t = $urandom;
        2: case ($urandom_range(2))
             0: t = 524287;
             1: t = -524288;
             default: t = 0;
           endcase
        default: t = $urandom_range(65535) - 32768;
      endcase
      v[k*COMP_W +: COMP_W] = COMP_W'(t);
    end
    return v;
  endfunction

  function automatic int rand_size();
    case ($urandom_range(9))
      0: return 256;
      1: return ($urandom_range(1) == 0) ? 0 : 300;
      2: return 1;
      default: return $urandom_range(24, 1);
    endcase
  endfunction

  task automatic rand_config();
    cfg_write(REG_GRID_COLS, VEC_W'(rand_size()));
    cfg_write(REG_GRID_ROWS, VEC_W'(rand_size()));
    cfg_write(REG_ORIGIN, rand_vec());
    cfg_write(REG_COL_STEP, rand_vec());
    cfg_write(REG_ROW_STEP, rand_vec());
    cfg_write(REG_HEIGHT_STEP, rand_vec());
  endtask

  // run limit
  initial begin
    #20_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    int target, c, r;
    sb = new();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: small 3 by 2 grid with plain axis steps
    cfg_write(REG_GRID_COLS, VEC_W'(3));
    cfg_write(REG_GRID_ROWS, VEC_W'(2));
    cfg_write(REG_ORIGIN, pack3(-65536, 0, 0));
    cfg_write(REG_COL_STEP, pack3(65536, 0, 0));
    cfg_write(REG_ROW_STEP, pack3(0, 65536, 0));
    cfg_write(REG_HEIGHT_STEP, pack3(0, 0, 256));
    write_height(0, 0, 16'h0000);
    write_height(1, 0, 16'hFFFF);
    write_height(255, 255, 16'hA5A5);
    query_point(0, 0);
    query_point(2, 1);
    query_point(1, 0);
    query_point(3, 0);
    query_point(0, 2);
    query_point(255, 255);
    // saturating vectors, one-column grid from a zero size
    drain();
    cfg_write(REG_GRID_COLS, VEC_W'(0));
    cfg_write(REG_ORIGIN, pack3(524287, 524287, 524287));
    cfg_write(REG_COL_STEP, pack3(524287, 524287, 524287));
    cfg_write(REG_HEIGHT_STEP, pack3(-524288, -524288, -524288));
    query_point(0, 1);
    query_point(1, 0);
    // oversized column count acts as full width, single row
    drain();
    cfg_write(REG_GRID_COLS, VEC_W'(300));
    cfg_write(REG_GRID_ROWS, VEC_W'(1));
    cfg_write(REG_ROW_STEP, pack3(-524288, -524288, -524288));
    query_point(255, 0);
    query_point(128, 0);
    // zero vectors give a degenerate normal
    drain();
    cfg_write(REG_GRID_ROWS, VEC_W'(256));
    cfg_write(REG_ORIGIN, '0);
    cfg_write(REG_COL_STEP, '0);
    cfg_write(REG_ROW_STEP, '0);
    cfg_write(REG_HEIGHT_STEP, '0);
    query_point(10, 10);
    drain();

    // random phases with changing idle pattern
    for (int ph = 0; ph < 3; ph++) begin
      snd_idle = (ph == 0) ? 28 : (ph == 1) ? 69 : 0;
      rcv_idle = (ph == 0) ? 69 : (ph == 1) ? 28 : 0;
      target = items_sent + 380;
      drain();
      rand_config();
      while (items_sent < target) begin
        if ($urandom_range(149) == 0) begin
          drain();
          rand_config();
        end else if ($urandom_range(3) == 0) begin
          if ($urandom_range(1) == 0) begin
            c = $urandom_range(sb.cols_eff() - 1);
            r = $urandom_range(sb.rows_eff() - 1);
          end else begin
            c = $urandom_range(255);
            r = $urandom_range(255);
          end
          case ($urandom_range(3))
            0: write_height(c, r, 16'h0000);
            1: write_height(c, r, 16'hFFFF);
            default: write_height(c, r, IN_H_W'($urandom));
          endcase
        end else if ($urandom_range(6) == 0) begin
          query_point($urandom_range(255), $urandom_range(255));
        end else begin
          query_point($urandom_range(sb.cols_eff() - 1), $urandom_range(sb.rows_eff() - 1));
        end
      end
    end

    drain();
    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

FILE: heightfield_vertex_normal_unit.f
rtl/hvn_pkg.sv
rtl/hvn_ram.sv
rtl/hvn_ctrl.sv
rtl/hvn_dp.sv
rtl/heightfield_vertex_normal_unit.sv
test/tb_heightfield_vertex_normal_unit.sv
